FILE: hdl/spq_pkg.sv
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PRIO_W = 2;
	localparam int TAG_W = 16;
	localparam int CODE_W = 16;
	localparam int PEND_W = 5;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [0:0] {
		ACT_ENQUEUE = 1'b0,
		ACT_DEQUEUE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ_SCAN,
		S_ENQ_PUT,
		S_DEQ_LOAD,
		S_DONE
	} state_t;

	typedef struct packed {
		action_t           action;
		logic [PRIO_W-1:0] prio_level;
		logic [TAG_W-1:0]  guest_tag;
		logic [CODE_W-1:0] request_code;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [TAG_W-1:0]  out_guest_tag;
		logic [CODE_W-1:0] out_request_code;
		logic [PRIO_W-1:0] out_prio_level;
		logic [PEND_W-1:0] pending_count;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
		logic [CODE_W-1:0] code;
	} entry_t;

	typedef struct packed {
		logic   we;
		ptr_t   waddr;
		entry_t wdata;
		ptr_t   raddr;
	} mem_port_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t p);
		ptr_t r;
		if (p == '0) begin
			r = ptr_t'(QUEUE_DEPTH - 1);
		end else begin
			r = p - 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: hdl/spq_mem.sv
module spq_mem (
	input  logic                clk,
	input  spq_pkg::mem_port_t  port,
	output spq_pkg::entry_t     rd_data
);

	spq_pkg::entry_t mem [spq_pkg::QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (port.we) begin
			mem[port.waddr] <= port.wdata;
		end
		rd_data <= mem[port.raddr];
	end

endmodule

FILE: hdl/spq_ctrl.sv
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  spq_pkg::req_t      req,
	output logic               req_ready,
	output spq_pkg::mem_port_t mem,
	input  spq_pkg::entry_t    rd_data,
	output logic               done,
	output spq_pkg::rsp_t      rsp,
	input  logic               take
);

	spq_pkg::state_t  state_q, state_d;
	spq_pkg::cnt_t    count_q;
	spq_pkg::ptr_t    head_q, tail_q, ptr_q;
	spq_pkg::entry_t  new_q, req_entry;
	spq_pkg::status_t res_status_q;
	spq_pkg::entry_t  res_entry_q;
	logic             accept, is_enq, is_full, is_empty, shift_en, at_head;

	assign accept    = req_valid && req_ready;
	assign is_enq    = (req.action == spq_pkg::ACT_ENQUEUE);
	assign is_full   = (count_q == spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH));
	assign is_empty  = (count_q == '0);
	assign req_entry = '{prio: req.prio_level, tag: req.guest_tag, code: req.request_code};
	assign shift_en  = (rd_data.prio < new_q.prio);
	assign at_head   = (ptr_q == head_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept) begin
					if (is_enq) begin
						state_d = (is_full || is_empty) ? spq_pkg::S_DONE : spq_pkg::S_ENQ_SCAN;
					end else begin
						state_d = is_empty ? spq_pkg::S_DONE : spq_pkg::S_DEQ_LOAD;
					end
				end
			end
			spq_pkg::S_ENQ_SCAN: begin
				if (!shift_en) begin
					state_d = spq_pkg::S_DONE;
				end else if (at_head) begin
					state_d = spq_pkg::S_ENQ_PUT;
				end
			end
			spq_pkg::S_ENQ_PUT:  state_d = spq_pkg::S_DONE;
			spq_pkg::S_DEQ_LOAD: state_d = spq_pkg::S_DONE;
			spq_pkg::S_DONE: begin
				if (take) begin
					state_d = spq_pkg::S_IDLE;
				end
			end
			default: state_d = spq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		done      = 1'b0;
		mem.we    = 1'b0;
		mem.waddr = ptr_q;
		mem.wdata = new_q;
		mem.raddr = head_q;
		case (state_q)
			spq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				mem.raddr = is_enq ? spq_pkg::ptr_dec(tail_q) : head_q;
				if (accept && is_enq && is_empty) begin
					mem.we    = 1'b1;
					mem.waddr = tail_q;
					mem.wdata = req_entry;
				end
			end
			spq_pkg::S_ENQ_SCAN: begin
				mem.we    = 1'b1;
				mem.waddr = spq_pkg::ptr_inc(ptr_q);
				mem.wdata = shift_en ? rd_data : new_q;
				mem.raddr = spq_pkg::ptr_dec(ptr_q);
			end
			spq_pkg::S_ENQ_PUT: begin
				mem.we = 1'b1;
			end
			spq_pkg::S_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign rsp = '{
		status:           res_status_q,
		out_guest_tag:    res_entry_q.tag,
		out_request_code: res_entry_q.code,
		out_prio_level:   res_entry_q.prio,
		pending_count:    spq_pkg::PEND_W'(count_q)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (is_enq && !is_full) begin
					count_q <= count_q + 1'b1;
					tail_q  <= spq_pkg::ptr_inc(tail_q);
				end else if (!is_enq && !is_empty) begin
					count_q <= count_q - 1'b1;
					head_q  <= spq_pkg::ptr_inc(head_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q       <= req_entry;
			ptr_q       <= spq_pkg::ptr_dec(tail_q);
			res_entry_q <= '0;
			if (is_enq) begin
				res_status_q <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
			end else begin
				res_status_q <= is_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DEQUEUED;
			end
		end
		if (state_q == spq_pkg::S_ENQ_SCAN && shift_en && !at_head) begin
			ptr_q <= spq_pkg::ptr_dec(ptr_q);
		end
		if (state_q == spq_pkg::S_DEQ_LOAD) begin
			res_entry_q <= rd_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH))
		else $error("entry count above depth");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(is_empty || is_full) |-> (head_q == tail_q))
		else $error("head and tail disagree with count");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_enq && !is_full) |=> (count_q == spq_pkg::cnt_t'($past(count_q) + 1'b1)))
		else $error("enqueue did not grow count");

	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_enq && is_empty) |=>
		(state_q == spq_pkg::S_DONE && res_status_q == spq_pkg::ST_EMPTY))
		else $error("dequeue on empty not reported");
`endif

endmodule

FILE: hdl/stable_priority_request_queue.sv
// Bounded stable priority queue of QUEUE_DEPTH requests held in a circular buffer
// in one memory. An enqueue inserts behind every held entry of equal or higher
// priority, so equal priorities leave in arrival order; a dequeue returns the head.
// Every request gives exactly one response. The single memory port pair sets the
// rate: an enqueue walks back from the tail one entry per cycle, moving each held
// entry of lower priority than the new one up a slot, then writes the new one; a
// dequeue reads the head in a load state; a request answered at once (enqueue into
// an empty or full queue, dequeue from an empty one) goes straight to done.
// A finished response waits in an output register while the next request enters.
module stable_priority_request_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::rsp_t rsp
);

	spq_pkg::mem_port_t mem_port;
	spq_pkg::entry_t    rd_data;
	spq_pkg::rsp_t      ctrl_rsp;
	spq_pkg::rsp_t      rsp_q;
	logic               ctrl_done, take, rsp_valid_q;

	assign take = !rsp_valid_q || rsp_ready;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.mem       (mem_port),
		.rd_data   (rd_data),
		.done      (ctrl_done),
		.rsp       (ctrl_rsp),
		.take      (take)
	);

	spq_mem u_mem (
		.clk     (clk),
		.port    (mem_port),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= ctrl_done;
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctrl_done) begin
			rsp_q <= ctrl_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_PER_PHASE = 450;
	localparam int PHASES = 4;
	localparam int SETTLE_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int IDLE_PCT [PHASES] = '{0, 49, 0, 21};
	localparam int STALL_PCT [PHASES] = '{0, 0, 49, 21};

	typedef struct packed {
		spq_pkg::req_t request;
		bit            pinned;
		spq_pkg::rsp_t want;
	} directed_row_t;

	localparam int DIRECTED_COUNT = 24;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{'{spq_pkg::ACT_DEQUEUE, 2'd0, 16'h0000, 16'h0000}, 1'b1,
			'{spq_pkg::ST_EMPTY, 16'h0000, 16'h0000, 2'd0, 5'd0}},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd3, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd1, 16'h1234, 16'h0001}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd3, 16'h0003, 16'h0003}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd2, 16'h0005, 16'h0005}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd0, 16'h0006, 16'h0006}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd1, 16'h0007, 16'h0007}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd2, 16'h0008, 16'h0008}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd3, 16'h0009, 16'h0009}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd0, 16'h000A, 16'h000A}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd3, 16'hAAAA, 16'h5555}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd0, 16'h5555, 16'hAAAA}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd2, 16'h000D, 16'h000D}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd1, 16'h000E, 16'h000E}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd2, 16'h000F, 16'h000F}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd1, 16'h0010, 16'h0010}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd3, 16'hBEEF, 16'hCAFE}, 1'b1,
			'{spq_pkg::ST_FULL, 16'h0000, 16'h0000, 2'd0, 5'd16}},
		'{'{spq_pkg::ACT_DEQUEUE, 2'd3, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
		'{'{spq_pkg::ACT_DEQUEUE, 2'd0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{spq_pkg::ACT_DEQUEUE, 2'd2, 16'h1111, 16'h2222}, 1'b0, '0},
		'{'{spq_pkg::ACT_ENQUEUE, 2'd3, 16'h0015, 16'h0015}, 1'b0, '0},
		'{'{spq_pkg::ACT_DEQUEUE, 2'd1, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{spq_pkg::ACT_DEQUEUE, 2'd0, 16'h0000, 16'h0000}, 1'b0, '0}
	};

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	spq_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	spq_pkg::rsp_t rsp;

	spq_pkg::entry_t model_entries [spq_pkg::QUEUE_DEPTH];
	int              model_held;
	spq_pkg::rsp_t   awaited_responses [$];
	int              mismatch_count;
	int              send_idle_pct;
	int              stall_pct;
	int              quiet_cycles;

	stable_priority_request_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic spq_pkg::rsp_t serve_request(input spq_pkg::req_t r);
		spq_pkg::rsp_t o;
		int            pos;
		int            i;
		o = '0;
		if (r.action == spq_pkg::ACT_ENQUEUE) begin
			if (model_held >= spq_pkg::QUEUE_DEPTH) begin
				o.status = spq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < model_held && model_entries[pos].prio >= r.prio_level) pos++;
				for (i = model_held; i > pos; i--) model_entries[i] = model_entries[i - 1];
				model_entries[pos] = '{r.prio_level, r.guest_tag, r.request_code};
				model_held++;
				o.status = spq_pkg::ST_ENQUEUED;
			end
		end else if (model_held == 0) begin
			o.status = spq_pkg::ST_EMPTY;
		end else begin
			o.status = spq_pkg::ST_DEQUEUED;
			o.out_guest_tag = model_entries[0].tag;
			o.out_request_code = model_entries[0].code;
			o.out_prio_level = model_entries[0].prio;
			for (i = 1; i < model_held; i++) model_entries[i - 1] = model_entries[i];
			model_held--;
		end
		o.pending_count = spq_pkg::PEND_W'(model_held);
		return o;
	endfunction

	function automatic spq_pkg::req_t random_request(input spq_pkg::action_t act);
		spq_pkg::req_t r;
		r.action = act;
		r.prio_level = spq_pkg::PRIO_W'($urandom_range(3));
		r.guest_tag = spq_pkg::TAG_W'($urandom);
		r.request_code = spq_pkg::CODE_W'($urandom);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic send_request(input spq_pkg::req_t r, input bit pinned,
		input spq_pkg::rsp_t want);
		spq_pkg::rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		predicted = serve_request(r);
		awaited_responses.insert(awaited_responses.size(), pinned ? want : predicted);
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(negedge clk); while (awaited_responses.size() != 0);
	endtask

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		spq_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_responses.size() == 0) begin
				$display("%0t: unexpected response, expected none, got %p", $time, rsp);
				mismatch_count++;
			end else begin
				want = awaited_responses.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("out_guest_tag", want.out_guest_tag, rsp.out_guest_tag);
				check_field("out_request_code", want.out_request_code, rsp.out_request_code);
				check_field("out_prio_level", want.out_prio_level, rsp.out_prio_level);
				check_field("pending_count", want.pending_count, rsp.pending_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("stable_priority_request_queue verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int               ph;
		int               sent;
		int               burst;
		int               mode;
		int               k;
		spq_pkg::action_t act;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		model_held = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DIRECTED_COUNT; k++) begin
			send_request(DIRECTED_ROWS[k].request, DIRECTED_ROWS[k].pinned,
				DIRECTED_ROWS[k].want);
		end
		wait_for_drain();

		for (ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = IDLE_PCT[ph];
			stall_pct = STALL_PCT[ph];
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				burst = $urandom_range(20, 1);
				mode = $urandom_range(9);
				if ($urandom_range(19) == 0) wait_for_drain();
				repeat (burst) begin
					if (mode < 4) act = spq_pkg::ACT_ENQUEUE;
					else if (mode < 8) act = spq_pkg::ACT_DEQUEUE;
					else act = spq_pkg::action_t'($urandom_range(1));
					send_request(random_request(act), 1'b0, '0);
					sent++;
				end
			end
			wait_for_drain();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && awaited_responses.size() == 0) begin
			$display("stable_priority_request_queue verification clean");
		end else begin
			$display("stable_priority_request_queue verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/spq_pkg.sv
hdl/spq_mem.sv
hdl/spq_ctrl.sv
hdl/stable_priority_request_queue.sv
bench/testbench.sv
